### rtl/core/sclw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sector cache tag engine
// no dependencies; imported by every module of the block

package sclw_pkg;

    localparam int DEF_ENTRIES     = 8;
    localparam int DEF_SECTOR_BITS = 32;
    localparam int RESET_IN_USE    = 8;
    localparam int IN_USE_W        = 4;
    localparam int S_TDATA_W       = 72;
    localparam int M_TDATA_W       = 40;

    // register index carried in paddr[2]
    localparam logic REG_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        FUNC_READ  = 3'd0,
        FUNC_ALLOC = 3'd1,
        FUNC_MARK  = 3'd2,
        FUNC_FLUSH = 3'd3,
        FUNC_INVAL = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CMD_DONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } disk_cmd_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_CLEAN = 2'd1,
        ST_DIRTY = 2'd2
    } entry_st_t;

    typedef enum logic [2:0] {
        EMIT_VIC_WB  = 3'd0,
        EMIT_FILL    = 3'd1,
        EMIT_SCAN_WB = 3'd2,
        EMIT_MARK_WB = 3'd3,
        EMIT_DONE    = 3'd4
    } emit_t;

    typedef struct packed {
        logic  load_req;
        logic  scan_step;
        logic  vic_commit;
        logic  mark_read;
        logic  mark_commit;
        logic  emit;
        emit_t emit_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic need_out;
        logic lookup;
        logic hit;
        logic vic_dirty;
        logic fill;
        logic mark_skip;
        logic wt;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/sclw_ctrl.sv
`timescale 1ns / 1ps
// request sequencer of the sector cache tag engine
// depends on sclw_pkg; drives sclw_datapath through dp_cmd_t

module sclw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           func,
    input  sclw_pkg::dp_status_t status,
    output sclw_pkg::dp_cmd_t    cmd
);
    import sclw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_VICTIM  = 8'b0000_0100,
        S_WB      = 8'b0000_1000,
        S_FILL    = 8'b0001_0000,
        S_MARK_RD = 8'b0010_0000,
        S_MARK_WB = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    case (func) inside
                        FUNC_READ, FUNC_ALLOC, FUNC_FLUSH, FUNC_INVAL: state_next = S_SCAN;
                        FUNC_MARK:                                     state_next = S_MARK_RD;
                        default:                                       state_next = S_FINISH;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = status.lookup ? S_VICTIM : S_FINISH;
                end
                else if (!status.need_out || status.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.need_out)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_SCAN_WB;
                    end
                end
            end
            S_VICTIM:
            begin
                cmd.vic_commit = 1'b1;
                if (status.hit)
                    state_next = S_FINISH;
                else if (status.vic_dirty)
                    state_next = S_WB;
                else if (status.fill)
                    state_next = S_FILL;
                else
                    state_next = S_FINISH;
            end
            S_WB:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_VIC_WB;
                    state_next    = status.fill ? S_FILL : S_FINISH;
                end
            end
            S_FILL:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_FILL;
                    state_next    = S_FINISH;
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_read = 1'b1;
                state_next    = S_MARK_WB;
            end
            S_MARK_WB:
            begin
                if (status.mark_skip)
                begin
                    state_next = S_FINISH;
                end
                else if (!status.wt)
                begin
                    cmd.mark_commit = 1'b1;
                    state_next      = S_FINISH;
                end
                else if (status.out_free)
                begin
                    cmd.mark_commit = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = EMIT_MARK_WB;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_DONE;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/sclw_datapath.sv
`timescale 1ns / 1ps
// tag memory, entry states, recency list, scan pipeline and result register
// depends on sclw_pkg; commanded by sclw_ctrl

module sclw_datapath #(
    parameter int ENTRIES     = sclw_pkg::DEF_ENTRIES,
    parameter int SECTOR_BITS = sclw_pkg::DEF_SECTOR_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sclw_pkg::dp_cmd_t    cmd,
    output sclw_pkg::dp_status_t status,
    input  logic                 relink,
    input  logic [3:0]           relink_n,
    input  logic [3:0]           in_use,
    input  logic [2:0]           func,
    input  logic [31:0]          sector,
    input  logic [31:0]          range_count,
    input  logic [2:0]           entry_index,
    input  logic                 write_through,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_command,
    output logic [31:0]          out_sector,
    output logic [2:0]           out_entry,
    output logic                 out_hit
);
    import sclw_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int POS_W = IDX_W + 1;
    localparam int CW    = (POS_W > IN_USE_W) ? POS_W : IN_USE_W;
    localparam int RST_N = (RESET_IN_USE > ENTRIES) ? ENTRIES : RESET_IN_USE;

    // recency list, entry states, tag valid bits
    logic [IDX_W-1:0]       order_reg [ENTRIES];
    logic [1:0]             state_reg [ENTRIES];
    logic [ENTRIES-1:0]     tag_vld_reg;
    logic [SECTOR_BITS-1:0] tag_mem [ENTRIES];
    logic [SECTOR_BITS-1:0] tag_rd_reg;
    logic                   rd_vld_reg;

    // latched request
    logic [2:0]             func_reg;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic [SECTOR_BITS-1:0] end_reg;
    logic [2:0]             idx_reg;
    logic                   wt_reg;

    // scan pipeline
    logic [POS_W-1:0]       a_pos_reg;
    logic                   b_valid_reg;
    logic [IDX_W-1:0]       b_pos_reg;
    logic [IDX_W-1:0]       b_q_reg;
    logic                   hit_reg;
    logic                   free_reg;
    logic [IDX_W-1:0]       hit_pos_reg;
    logic [IDX_W-1:0]       free_pos_reg;
    logic [IDX_W-1:0]       vic_e_reg;

    // result register
    logic                   out_valid_reg;
    disk_cmd_t              out_cmd_reg;
    logic [31:0]            out_sec_reg;
    logic [2:0]             out_ent_reg;
    logic                   out_hit_reg;

    logic [SECTOR_BITS-1:0] tag_rd;
    logic [1:0]             b_state;
    logic                   b_used;
    logic                   b_in_range;
    logic                   a_more;
    logic [IDX_W-1:0]       a_q;
    logic [IDX_W-1:0]       vp;
    logic [IDX_W-1:0]       vic_e;
    logic [IDX_W-1:0]       m_idx;
    logic                   is_lookup;
    logic                   need_out;
    logic                   inval_hit;
    logic                   out_free;

    assign tag_rd     = rd_vld_reg ? tag_rd_reg : '0;
    assign b_state    = state_reg[b_q_reg];
    assign b_used     = (b_state == ST_CLEAN) || (b_state == ST_DIRTY);
    assign b_in_range = (tag_rd >= sec_reg) && (tag_rd <= end_reg);
    assign a_more     = CW'(a_pos_reg) < CW'(in_use);
    assign a_q        = order_reg[a_pos_reg[IDX_W-1:0]];
    assign vp         = hit_reg ? hit_pos_reg :
                        (free_reg ? free_pos_reg : IDX_W'(in_use - 4'd1));
    assign vic_e      = order_reg[vp];
    assign m_idx      = IDX_W'(idx_reg);
    assign is_lookup  = (func_reg == FUNC_READ) || (func_reg == FUNC_ALLOC);
    assign need_out   = b_valid_reg && (func_reg == FUNC_FLUSH) &&
                        (b_state == ST_DIRTY) && b_in_range;
    assign inval_hit  = b_valid_reg && (func_reg == FUNC_INVAL) && b_used && b_in_range;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        status           = '0;
        status.scan_done = hit_reg || (!b_valid_reg && !a_more);
        status.need_out  = need_out;
        status.lookup    = is_lookup;
        status.hit       = hit_reg;
        status.vic_dirty = (state_reg[vic_e] == ST_DIRTY);
        status.fill      = (func_reg == FUNC_READ);
        status.mark_skip = ({1'b0, idx_reg} >= in_use);
        status.wt        = wt_reg;
        status.out_free  = out_free;
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < ENTRIES; p++)
            begin
                order_reg[p] <= (p < RST_N) ? IDX_W'(RST_N - 1 - p) : IDX_W'(p);
                state_reg[p] <= ST_FREE;
            end
            tag_vld_reg   <= '0;
            a_pos_reg     <= '0;
            b_valid_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (relink)
            begin
                for (int p = 0; p < ENTRIES; p++)
                begin
                    order_reg[p] <= (p < int'(relink_n)) ?
                                    IDX_W'(int'(relink_n) - 1 - p) : IDX_W'(p);
                    state_reg[p] <= ST_FREE;
                end
                tag_vld_reg <= '0;
            end
            else
            begin
                if (cmd.load_req)
                begin
                    a_pos_reg   <= '0;
                    b_valid_reg <= 1'b0;
                    hit_reg     <= 1'b0;
                    free_reg    <= 1'b0;
                end
                if (cmd.scan_step)
                begin
                    a_pos_reg   <= a_more ? a_pos_reg + POS_W'(1) : a_pos_reg;
                    b_valid_reg <= a_more;
                    if (b_valid_reg && is_lookup && !hit_reg)
                    begin
                        if (b_state == ST_FREE)
                            free_reg <= 1'b1;
                        else if (b_used && (tag_rd == sec_reg))
                            hit_reg <= 1'b1;
                    end
                    if (need_out)
                        state_reg[b_q_reg] <= ST_CLEAN;
                    else if (inval_hit)
                        state_reg[b_q_reg] <= ST_FREE;
                end
                if (cmd.vic_commit)
                begin
                    // move to front
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if (IDX_W'(i) <= vp)
                            order_reg[i] <= order_reg[i-1];
                    end
                    order_reg[0] <= vic_e;
                    if (!hit_reg)
                    begin
                        state_reg[vic_e]   <= ST_CLEAN;
                        tag_vld_reg[vic_e] <= 1'b1;
                    end
                end
                if (cmd.mark_commit)
                    state_reg[m_idx] <= wt_reg ? ST_CLEAN : ST_DIRTY;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, tag memory and positions
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= func;
            sec_reg  <= SECTOR_BITS'(sector);
            end_reg  <= SECTOR_BITS'(sector) + SECTOR_BITS'(range_count) - SECTOR_BITS'(1);
            idx_reg  <= entry_index;
            wt_reg   <= write_through;
        end
        if (cmd.scan_step)
        begin
            if (a_more)
            begin
                tag_rd_reg <= tag_mem[a_q];
                rd_vld_reg <= tag_vld_reg[a_q];
                b_q_reg    <= a_q;
                b_pos_reg  <= a_pos_reg[IDX_W-1:0];
            end
            if (b_valid_reg && is_lookup && !hit_reg)
            begin
                if (b_state == ST_FREE)
                    free_pos_reg <= b_pos_reg;
                else if (b_used && (tag_rd == sec_reg))
                    hit_pos_reg <= b_pos_reg;
            end
        end
        else if (cmd.mark_read)
        begin
            tag_rd_reg <= tag_mem[m_idx];
            rd_vld_reg <= tag_vld_reg[m_idx];
        end
        if (cmd.vic_commit)
        begin
            vic_e_reg <= vic_e;
            if (!hit_reg)
                tag_mem[vic_e] <= sec_reg;
        end
        if (cmd.emit)
        begin
            // hit is reported only on the done of a lookup
            out_hit_reg <= (cmd.emit_kind == EMIT_DONE) && is_lookup && hit_reg;
            case (cmd.emit_kind)
                EMIT_VIC_WB:
                begin
                    out_cmd_reg <= CMD_WRITE;
                    out_sec_reg <= 32'(tag_rd);
                    out_ent_reg <= 3'(vic_e_reg);
                end
                EMIT_FILL:
                begin
                    out_cmd_reg <= CMD_READ;
                    out_sec_reg <= 32'(sec_reg);
                    out_ent_reg <= 3'(vic_e_reg);
                end
                EMIT_SCAN_WB:
                begin
                    out_cmd_reg <= CMD_WRITE;
                    out_sec_reg <= 32'(tag_rd);
                    out_ent_reg <= 3'(b_q_reg);
                end
                EMIT_MARK_WB:
                begin
                    out_cmd_reg <= CMD_WRITE;
                    out_sec_reg <= 32'(tag_rd);
                    out_ent_reg <= idx_reg;
                end
                default:
                begin
                    out_cmd_reg <= CMD_DONE;
                    if (is_lookup)
                    begin
                        out_sec_reg <= 32'(sec_reg);
                        out_ent_reg <= 3'(vic_e_reg);
                    end
                    else if (func_reg == FUNC_MARK)
                    begin
                        // ignored mark reports sector zero
                        out_sec_reg <= status.mark_skip ? 32'd0 : 32'(tag_rd);
                        out_ent_reg <= idx_reg;
                    end
                    else
                    begin
                        out_sec_reg <= 32'(sec_reg);
                        out_ent_reg <= 3'd0;
                    end
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_command = out_cmd_reg;
    assign out_sector  = out_sec_reg;
    assign out_entry   = out_ent_reg;
    assign out_hit     = out_hit_reg;

endmodule

### rtl/core/sector_cache_lru_writeback.sv
`timescale 1ns / 1ps
// top level of the fully associative lru write-back sector cache tag engine
// depends on sclw_pkg, sclw_ctrl, sclw_datapath
//
// usage:
// - request channel s_*: s_tuser carries the function code, s_tdata the
//   sector, range count, entry index and write-through flag
// - result channel m_*: m_tuser carries the disk command, m_tdata the disk
//   sector, entry and hit flag; m_tlast marks the done result that closes
//   every request (write-back and fill commands come before it)
// - one request is in work at a time; s_tready is high only when idle
// - lookup (read or allocate): the request is taken; the list of entries_in_use
//   entries is scanned from the front, one tag memory read per cycle, until a
//   hit; then the victim step, then each result in turn
// - flush and invalidate: take, scan, done; a write-back found during the scan
//   goes out with its scan step, which waits while the output register is full
// - mark written: take, tag read, commit, done; unknown functions: take, done
// - a result sits in the output register until taken; while it is full the
//   engine waits before loading its next result, and the next request may be
//   taken once the done result is loaded
// - reset: all entries free, tags zero, list ordered highest entry at the
//   front; writing entries_in_use through the apb port relinks the same way

module sector_cache_lru_writeback #(
    parameter int ENTRIES     = sclw_pkg::DEF_ENTRIES,
    parameter int SECTOR_BITS = sclw_pkg::DEF_SECTOR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request: s_tdata = sector[31:0], range_count[63:32], entry_index[66:64],
    // write_through[67], zero fill [71:68]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sclw_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser = func[2:0]
    input  logic [2:0]                     s_tuser,
    // result: m_tdata = disk_sector[31:0], out_entry[34:32], hit[35], zero fill [39:36]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sclw_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser = command[1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sclw_pkg::*;

    localparam logic [3:0] IN_USE_RST =
        4'((RESET_IN_USE > ENTRIES) ? ENTRIES : RESET_IN_USE);

    logic [3:0]  in_use_reg;
    logic [3:0]  in_use_next;
    logic        cfg_write;
    dp_cmd_t     dp_cmd;
    dp_status_t  dp_status;
    logic [1:0]  out_command;
    logic [31:0] out_sector;
    logic [2:0]  out_entry;
    logic        out_hit;

    // entries_in_use register, clamped to 1..ENTRIES
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IN_USE);

    always_comb
    begin
        if (pwdata[3:0] == 4'd0)
            in_use_next = 4'd1;
        else if (int'(pwdata[3:0]) > ENTRIES)
            in_use_next = 4'(ENTRIES);
        else
            in_use_next = pwdata[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_use_reg <= IN_USE_RST;
        else if (cfg_write)
            in_use_reg <= in_use_next;
    end

    assign prdata = (paddr[2] == REG_IN_USE) ? {28'd0, in_use_reg} : 32'd0;

    sclw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .func     (s_tuser),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    sclw_datapath #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .relink        (cfg_write),
        .relink_n      (in_use_next),
        .in_use        (in_use_reg),
        .func          (s_tuser),
        .sector        (s_tdata[31:0]),
        .range_count   (s_tdata[63:32]),
        .entry_index   (s_tdata[66:64]),
        .write_through (s_tdata[67]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_command   (out_command),
        .out_sector    (out_sector),
        .out_entry     (out_entry),
        .out_hit       (out_hit)
    );

    assign m_tuser = out_command;
    assign m_tlast = (out_command == CMD_DONE);
    assign m_tdata = {4'd0, out_hit, out_entry, out_sector};

endmodule

### rtl/core/sclw_checker.sv
`timescale 1ns / 1ps
// port-level checks of the sector cache tag engine
// depends on sclw_pkg; bound to sector_cache_lru_writeback

module sclw_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sclw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);
    import sclw_pkg::*;

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // last marks exactly the done result
    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == CMD_DONE)))
        else $error("last does not match done");

    // when idle, only a done result may still wait
    a_idle_tail: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(m_tvalid && !m_tlast))
        else $error("idle with an unfinished request");

endmodule

bind sector_cache_lru_writeback sclw_checker u_sclw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the lru write-back sector cache tag engine
// depends on sclw_pkg and sector_cache_lru_writeback; keeps its own copy of tags, states and order

module testbench;

    import sclw_pkg::*;

    localparam int LONG_HOLD   = 200;     // cycles the result side holds off once
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 57;

    // one request as it travels on the s_* channel
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] sector;
        logic [31:0] count;
        logic [2:0]  idx;
        logic        wt;
    } cache_req_t;

    // one result as it travels on the m_* channel
    typedef struct packed {
        disk_cmd_t   cmd;
        logic [31:0] sector;
        logic [2:0]  entry;
        logic        hit;
        logic        last;
    } disk_result_t;

    // a line of the directed plan: either a request or a register write
    // (the value sits in the sector column), with an optional typed done result
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  func;
        logic [31:0] sector;
        logic [31:0] count;
        logic [2:0]  idx;
        logic        wt;
        logic        typed;
        logic [31:0] d_sector;
        logic [2:0]  d_entry;
        logic        d_hit;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // mirror of the engine state
    logic [31:0] tag_mirror [8];
    entry_st_t   state_mirror [8];
    logic [2:0]  order_mirror [8];
    int          in_use_mirror;

    disk_result_t pending_results [$];   // results still owed by the engine, oldest first
    disk_result_t step_res [$];          // results of the request just predicted
    plan_row_t    plan [$];

    int          error_count = 0;
    bit          send_gaps;
    bit          take_gaps;
    bit          hold_off_req = 1'b0;
    logic [31:0] pool_base;

    sector_cache_lru_writeback dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, well beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // all entries free, tags zero, list from in_use-1 at the front down to entry 0
    function automatic void relink_entries();
        int p;
        for (p = 0; p < 8; p++)
        begin
            tag_mirror[p]   = '0;
            state_mirror[p] = ST_FREE;
            order_mirror[p] = (p < in_use_mirror) ? 3'(in_use_mirror - 1 - p) : 3'(p);
        end
    endfunction

    function automatic void apply_in_use(input logic [31:0] v);
        int n;
        n = int'(v[3:0]);
        if (n < 1)
            n = 1;
        if (n > 8)
            n = 8;
        in_use_mirror = n;
        relink_entries();
    endfunction

    function automatic void add_result(input disk_cmd_t c, input logic [31:0] s,
                                       input logic [2:0] e, input logic h);
        disk_result_t res;
        res.cmd    = c;
        res.sector = s;
        res.entry  = e;
        res.hit    = h;
        res.last   = (c == CMD_DONE);
        step_res.push_back(res);
    endfunction

    function automatic bit tag_in_range(input logic [31:0] t, input logic [31:0] lo,
                                        input logic [31:0] hi);
        return (t >= lo) && (t <= hi);
    endfunction

    function automatic void predict_request(input cache_req_t r);
        int          hit_pos;
        int          free_pos;
        int          vic_pos;
        int          p;
        logic [2:0]  e;
        logic [2:0]  q;
        logic [31:0] range_end;
        step_res.delete();
        // range end wraps modulo 2^32; a range whose end falls below its start matches nothing
        range_end = r.sector + r.count - 32'd1;
        case (r.func)
            FUNC_READ, FUNC_ALLOC:
            begin
                hit_pos  = -1;
                free_pos = -1;
                // scan from the front; the last free slot seen is the one nearest the tail
                for (p = 0; p < in_use_mirror && hit_pos < 0; p++)
                begin
                    q = order_mirror[p];
                    if (state_mirror[q] == ST_FREE)
                        free_pos = p;
                    else if ((state_mirror[q] == ST_CLEAN || state_mirror[q] == ST_DIRTY)
                             && tag_mirror[q] == r.sector)
                        hit_pos = p;
                end
                vic_pos = (hit_pos >= 0) ? hit_pos
                        : (free_pos >= 0) ? free_pos : in_use_mirror - 1;
                e = order_mirror[vic_pos];
                for (p = vic_pos; p > 0; p--)
                    order_mirror[p] = order_mirror[p - 1];
                order_mirror[0] = e;
                if (hit_pos >= 0)
                    add_result(CMD_DONE, r.sector, e, 1'b1);
                else
                begin
                    if (state_mirror[e] == ST_DIRTY)
                        add_result(CMD_WRITE, tag_mirror[e], e, 1'b0);
                    if (r.func == FUNC_READ)
                        add_result(CMD_READ, r.sector, e, 1'b0);
                    state_mirror[e] = ST_CLEAN;
                    tag_mirror[e]   = r.sector;
                    add_result(CMD_DONE, r.sector, e, 1'b0);
                end
            end
            FUNC_MARK:
            begin
                // an index outside the linked list is ignored; a free entry still acts
                if (r.idx >= in_use_mirror)
                    add_result(CMD_DONE, 32'd0, r.idx, 1'b0);
                else
                begin
                    if (r.wt)
                    begin
                        add_result(CMD_WRITE, tag_mirror[r.idx], r.idx, 1'b0);
                        state_mirror[r.idx] = ST_CLEAN;
                    end
                    else
                        state_mirror[r.idx] = ST_DIRTY;
                    add_result(CMD_DONE, tag_mirror[r.idx], r.idx, 1'b0);
                end
            end
            FUNC_FLUSH:
            begin
                for (p = 0; p < in_use_mirror; p++)
                begin
                    q = order_mirror[p];
                    if (state_mirror[q] == ST_DIRTY
                        && tag_in_range(tag_mirror[q], r.sector, range_end))
                    begin
                        add_result(CMD_WRITE, tag_mirror[q], q, 1'b0);
                        state_mirror[q] = ST_CLEAN;
                    end
                end
                add_result(CMD_DONE, r.sector, 3'd0, 1'b0);
            end
            FUNC_INVAL:
            begin
                for (p = 0; p < in_use_mirror; p++)
                begin
                    q = order_mirror[p];
                    if ((state_mirror[q] == ST_CLEAN || state_mirror[q] == ST_DIRTY)
                        && tag_in_range(tag_mirror[q], r.sector, range_end))
                        state_mirror[q] = ST_FREE;
                end
                add_result(CMD_DONE, r.sector, 3'd0, 1'b0);
            end
            default:
                // unknown function: no state change, just done
                add_result(CMD_DONE, r.sector, 3'd0, 1'b0);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
            $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    // every accepted result is compared with the oldest one still owed
    always @(posedge clk)
    begin : take_result
        disk_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_tdata[31:0], 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser != want.cmd)
                    report_mismatch("command", 32'(m_tuser), 32'(want.cmd));
                if (m_tdata[31:0] != want.sector)
                    report_mismatch("disk sector", m_tdata[31:0], want.sector);
                if (m_tdata[34:32] != want.entry)
                    report_mismatch("entry", 32'(m_tdata[34:32]), 32'(want.entry));
                if (m_tdata[35] != want.hit)
                    report_mismatch("hit", 32'(m_tdata[35]), 32'(want.hit));
                if (m_tlast != want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random hold-off per result, plus one long hold on request
    // ------------------------------------------------------------------

    initial
    begin : result_side
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // long stall so the output register fills and s_tready drops
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = take_gaps ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // called at a falling edge, returns at a falling edge with s_tvalid still high
    task automatic send_req(input cache_req_t r, input bit typed, input disk_result_t tdone);
        int gap;
        gap = send_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {4'b0000, r.wt, r.idx, r.count, r.sector};
        s_tuser  <= r.func;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_request(r);
        if (typed)
            pending_results.push_back(tdone);
        else
            foreach (step_res[k])
                pending_results.push_back(step_res[k]);
        @(negedge clk);
    endtask

    // stop offering and wait until the engine owes nothing
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // apb write of entries_in_use: setup cycle, then access cycle
    task automatic write_in_use(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IN_USE, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_in_use(v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic cache_req_t random_req();
        cache_req_t r;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            r.func = FUNC_READ;
        else if (roll < 50)
            r.func = FUNC_ALLOC;
        else if (roll < 72)
            r.func = FUNC_MARK;
        else if (roll < 84)
            r.func = FUNC_FLUSH;
        else if (roll < 95)
            r.func = FUNC_INVAL;
        else
            r.func = 3'($urandom_range(5, 7));
        // mostly a small pool of sectors so hits and dirty evictions happen often
        roll = $urandom_range(0, 99);
        if (roll < 75)
            r.sector = pool_base + 32'($urandom_range(0, 11));
        else if (roll < 88)
            r.sector = $urandom;
        else
            case ($urandom_range(0, 2))
                0:       r.sector = 32'h0000_0000;
                1:       r.sector = 32'hFFFF_FFFF;
                default: r.sector = 32'h8000_0000;
            endcase
        roll = $urandom_range(0, 99);
        if (r.func == FUNC_FLUSH || r.func == FUNC_INVAL)
        begin
            if (roll < 55)
                r.count = 32'($urandom_range(1, 12));
            else if (roll < 65)
                r.count = 32'd0;
            else
                r.count = $urandom;
        end
        else
            r.count = $urandom;
        if (r.func == FUNC_MARK && $urandom_range(0, 99) < 85)
            r.idx = 3'($urandom_range(0, in_use_mirror - 1));
        else
            r.idx = 3'($urandom_range(0, 7));
        r.wt = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic plan_row_t req_row(input logic [2:0] f, input logic [31:0] s,
                                          input logic [31:0] c, input logic [2:0] i,
                                          input logic w);
        plan_row_t row;
        row        = '0;
        row.func   = f;
        row.sector = s;
        row.count  = c;
        row.idx    = i;
        row.wt     = w;
        return row;
    endfunction

    function automatic plan_row_t done_row(input logic [2:0] f, input logic [31:0] s,
                                           input logic [31:0] c, input logic [2:0] i,
                                           input logic w, input logic [31:0] ds,
                                           input logic [2:0] de, input logic dh);
        plan_row_t row;
        row          = req_row(f, s, c, i, w);
        row.typed    = 1'b1;
        row.d_sector = ds;
        row.d_entry  = de;
        row.d_hit    = dh;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [31:0] v);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.sector = v;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        cache_req_t   r;
        disk_result_t tdone;
        disk_result_t none_res;
        logic [31:0]  cfg_seq [RAND_PHASES];
        int           ph;
        int           i;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        send_gaps = 1'b1;
        take_gaps = 1'b1;
        pool_base = 32'd0;
        none_res  = '0;

        in_use_mirror = RESET_IN_USE;
        relink_entries();

        // directed plan; rows with a typed done are read straight off the spec,
        // the rest go through the predictor
        //                    func        sector         count          idx   wt
        plan.push_back(done_row(3'd5,      32'hFFFF_FFFF, 32'd0,         3'd7, 1'b1,
                                32'hFFFF_FFFF, 3'd0, 1'b0));   // unknown function
        plan.push_back(done_row(3'd7,      32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 1'b0,
                                32'h0000_0000, 3'd0, 1'b0));   // unknown function
        plan.push_back(done_row(FUNC_MARK, 32'd0,         32'd0,         3'd7, 1'b0,
                                32'h0000_0000, 3'd7, 1'b0));   // mark on a free entry
        plan.push_back(req_row(FUNC_READ,  32'hFFFF_FFFF, 32'd0,         3'd0, 1'b0));
        plan.push_back(req_row(FUNC_READ,  32'h0000_0000, 32'd1,         3'd0, 1'b0));
        plan.push_back(req_row(FUNC_ALLOC, 32'h8000_0000, 32'd0,         3'd5, 1'b1));
        plan.push_back(req_row(FUNC_MARK,  32'd0,         32'd0,         3'd1, 1'b1));
        plan.push_back(req_row(FUNC_MARK,  32'd0,         32'd0,         3'd0, 1'b0));
        // start zero with count zero covers the whole sector space
        plan.push_back(req_row(FUNC_FLUSH, 32'h0000_0000, 32'd0,         3'd0, 1'b0));
        plan.push_back(req_row(FUNC_MARK,  32'd0,         32'd0,         3'd7, 1'b0));
        plan.push_back(done_row(FUNC_FLUSH, 32'd5,        32'd0,         3'd0, 1'b0,
                                32'd5, 3'd0, 1'b0));           // count zero, empty
        plan.push_back(done_row(FUNC_FLUSH, 32'hFFFF_FFFF, 32'd2,        3'd0, 1'b0,
                                32'hFFFF_FFFF, 3'd0, 1'b0));   // wrapped range, empty
        plan.push_back(req_row(FUNC_FLUSH, 32'h0000_0000, 32'd1,         3'd0, 1'b0));
        plan.push_back(done_row(FUNC_INVAL, 32'h8000_0000, 32'h8000_0000, 3'd0, 1'b0,
                                32'h8000_0000, 3'd0, 1'b0));
        plan.push_back(done_row(FUNC_INVAL, 32'h0000_0000, 32'd0,        3'd0, 1'b0,
                                32'h0000_0000, 3'd0, 1'b0));   // frees everything
        plan.push_back(req_row(FUNC_ALLOC, 32'h1234_5678, 32'd0,         3'd0, 1'b0));
        plan.push_back(cfg_row(32'd0));                        // clamps up to one entry
        plan.push_back(req_row(FUNC_READ,  32'hA5A5_A5A5, 32'd0,         3'd0, 1'b0));
        plan.push_back(req_row(FUNC_MARK,  32'd0,         32'd0,         3'd0, 1'b0));
        plan.push_back(req_row(FUNC_READ,  32'h5A5A_5A5A, 32'd0,         3'd0, 1'b0));
        plan.push_back(done_row(FUNC_MARK, 32'd0,         32'd0,         3'd1, 1'b1,
                                32'd0, 3'd1, 1'b0));           // index past the list
        plan.push_back(done_row(FUNC_MARK, 32'd0,         32'd0,         3'd7, 1'b0,
                                32'd0, 3'd7, 1'b0));
        plan.push_back(req_row(FUNC_ALLOC, 32'h5A5A_5A5A, 32'd0,         3'd0, 1'b0));
        plan.push_back(cfg_row(32'h0000_001F));                // low nibble clamps to eight
        plan.push_back(req_row(FUNC_READ,  32'h0000_0001, 32'hFFFF_FFFF, 3'd6, 1'b1));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
            begin
                drain();
                write_in_use(plan[k].sector);
            end
            else
            begin
                r.func       = plan[k].func;
                r.sector     = plan[k].sector;
                r.count      = plan[k].count;
                r.idx        = plan[k].idx;
                r.wt         = plan[k].wt;
                tdone.cmd    = CMD_DONE;
                tdone.sector = plan[k].d_sector;
                tdone.entry  = plan[k].d_entry;
                tdone.hit    = plan[k].d_hit;
                tdone.last   = 1'b1;
                send_req(r, plan[k].typed, tdone);
            end
        end

        // random phases, each after its own write of the list length; extremes included
        cfg_seq[0] = 32'd15;
        cfg_seq[1] = 32'd2;
        cfg_seq[2] = 32'd5;
        cfg_seq[3] = 32'd8;
        cfg_seq[4] = 32'd3;
        cfg_seq[5] = 32'd7;
        cfg_seq[6] = 32'd1;
        cfg_seq[7] = 32'hFFFF_FFF4;
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            write_in_use(cfg_seq[ph]);
            // first phase runs back to back on both sides
            send_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
            take_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
            if (ph == 1)
                pool_base = 32'hFFFF_FFF8;   // pool straddles the top of the space
            else if (ph == 5)
                pool_base = 32'd0;
            else
                pool_base = $urandom;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == 20)
                    hold_off_req = 1'b1;     // sender keeps offering through the hold
                if (ph == 4 && i == 30)
                    drain();                 // sender pause until nothing is owed
                send_req(random_req(), 1'b0, none_res);
            end
        end

        drain();
        // catch any stray result after the last one owed
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
